// ----- sv/smsf_pkg.sv -----
// ----------------------------------------------------------------------------
// smsf_pkg: shared definitions for the scaled moving sum filter
// Widths, depths and register indexes used by the filter, its item
// interfaces and its checker.
// ----------------------------------------------------------------------------
package smsf_pkg;

  localparam int MaxLength    = 1024;
  localparam int AddrWidth    = $clog2(MaxLength);
  localparam int LenWidth     = AddrWidth + 1;
  localparam int SampleWidth  = 16;
  localparam int ScaleWidth   = 16;
  localparam int SumWidth     = SampleWidth + LenWidth;
  localparam int ProdWidth    = SumWidth + ScaleWidth;
  localparam int OutWidth     = 42;
  localparam int CfgIdxWidth  = 1;
  localparam int CfgDataWidth = ScaleWidth;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegWindowLength = 1'b0,
    RegScaleFactor  = 1'b1
  } reg_idx_e;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [ScaleWidth-1:0]  scale_t;
  typedef logic signed [SumWidth-1:0]    sum_t;
  typedef logic signed [OutWidth-1:0]    result_t;

endpackage

// ----- sv/smsf_if.sv -----
// ----------------------------------------------------------------------------
// smsf_if: item channels of the scaled moving sum filter
// Valid/ready channels for input samples and for filter results.
// ----------------------------------------------------------------------------
interface smsf_sample_if;
  logic              valid;
  logic              ready;
  smsf_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface smsf_result_if;
  logic              valid;
  logic              ready;
  smsf_pkg::result_t average_out;

  modport source (output valid, output average_out, input ready);
  modport sink (input valid, input average_out, output ready);
endinterface

// ----- sv/scaled_moving_sum_filter.sv -----
// ----------------------------------------------------------------------------
// scaled_moving_sum_filter: boxcar moving sum with signed scaling
// Keeps a circular sample history and a running window sum, and returns the
// sum times a signed scale factor for every sample.
//
//   Channel   Direction  Payload             Accepted when
//   din_i     in         sample[15:0]        din_i.valid && din_i.ready
//   dout_o    out        average_out[41:0]   dout_o.valid && dout_o.ready
//   cfg       in         cfg_idx_i, data     cfg_we_i
//
// One item per cycle while the result side takes results.
// The stages are the history read register, the running sum and the product.
// Reset and a window length write give an empty history at once; a fill
// count stands in for clearing the history memory, so no clearing pass.
// Each stage holds while the next is full and cannot move on, so input stalls
// only when all three stages hold items and the result is not taken.
// ----------------------------------------------------------------------------
module scaled_moving_sum_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [smsf_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [smsf_pkg::CfgDataWidth-1:0]   cfg_data_i,
  smsf_sample_if.sink                         din_i,
  smsf_result_if.source                       dout_o
);

  logic [smsf_pkg::LenWidth-1:0]  len_q, len_d;
  smsf_pkg::scale_t               scale_q;
  logic [smsf_pkg::AddrWidth-1:0] wp_q, rd_addr;
  logic [smsf_pkg::LenWidth-1:0]  fill_q;
  logic                           v1_q, v2_q, v3_q;
  smsf_pkg::sample_t              smp1_q, old1_q;
  logic                           hit1_q;
  smsf_pkg::sum_t                 acc_q, acc_d, leave;
  logic signed [smsf_pkg::ProdWidth-1:0] prod;
  smsf_pkg::result_t              out_q;
  smsf_pkg::sample_t              hist_mem [smsf_pkg::MaxLength];
  logic                           adv1, adv2, in_acc, mv12, mv23, len_wr;

  assign adv2   = !v3_q || dout_o.ready;
  assign adv1   = !v2_q || adv2;
  assign din_i.ready = !v1_q || adv1;
  assign in_acc = din_i.valid && din_i.ready;
  assign mv12   = v1_q && adv1;
  assign mv23   = v2_q && adv2;

  assign rd_addr = wp_q - len_q[smsf_pkg::AddrWidth-1:0];
  assign leave   = hit1_q ? smsf_pkg::sum_t'(old1_q) : '0;
  assign acc_d   = acc_q + smsf_pkg::sum_t'(smp1_q) - leave;
  assign prod    = acc_q * scale_q;

  always_comb begin
    len_wr = 1'b0;
    unique case (smsf_pkg::reg_idx_e'(cfg_idx_i))
      smsf_pkg::RegWindowLength: len_wr = cfg_we_i;
      smsf_pkg::RegScaleFactor:  len_wr = 1'b0;
      default:                   len_wr = 1'b0;
    endcase
  end

  always_comb begin
    len_d = cfg_data_i[smsf_pkg::LenWidth-1:0];
    if (len_d == '0) begin
      len_d = smsf_pkg::LenWidth'(1);
    end else if (len_d > smsf_pkg::LenWidth'(smsf_pkg::MaxLength)) begin
      len_d = smsf_pkg::LenWidth'(smsf_pkg::MaxLength);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= smsf_pkg::LenWidth'(1);
      scale_q <= smsf_pkg::scale_t'(1);
      wp_q    <= '0;
      fill_q  <= '0;
      acc_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      if (cfg_we_i && (smsf_pkg::reg_idx_e'(cfg_idx_i) == smsf_pkg::RegScaleFactor)) begin
        scale_q <= cfg_data_i;
      end
      if (in_acc) begin
        wp_q <= wp_q + 1'b1;
        if (fill_q != smsf_pkg::LenWidth'(smsf_pkg::MaxLength)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (mv12) begin
        acc_q <= acc_d;
      end
      if (len_wr) begin
        len_q  <= len_d;
        wp_q   <= '0;
        fill_q <= '0;
        acc_q  <= '0;
      end
      v1_q <= in_acc ? 1'b1 : (mv12 ? 1'b0 : v1_q);
      v2_q <= mv12 ? 1'b1 : (mv23 ? 1'b0 : v2_q);
      v3_q <= mv23 ? 1'b1 : (dout_o.ready ? 1'b0 : v3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hist_mem[wp_q] <= din_i.sample;
      old1_q         <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp1_q <= din_i.sample;
      hit1_q <= fill_q >= len_q;
    end
    if (mv23) begin
      out_q <= prod[smsf_pkg::OutWidth-1:0];
    end
  end

  assign dout_o.valid       = v3_q;
  assign dout_o.average_out = out_q;

endmodule

// ----- sv/smsf_checker.sv -----
// ----------------------------------------------------------------------------
// smsf_checker: port-level checks for the scaled moving sum filter
// Watches the channels and flags stalls, latency slips and changed results.
// ----------------------------------------------------------------------------
module smsf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input smsf_pkg::result_t out_data_i
);

  // The input must never stall while the result side is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled while the result side was free");

  // With the result side taking items, an accepted sample reaches the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("result missing three cycles after its item");

  // A waiting result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("waiting result changed or dropped");

endmodule

bind scaled_moving_sum_filter smsf_checker u_smsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (din_i.valid),
  .in_ready_i  (din_i.ready),
  .out_valid_i (dout_o.valid),
  .out_ready_i (dout_o.ready),
  .out_data_i  (dout_o.average_out)
);

// ----- bench/scaled_moving_sum_filter_tb.sv -----
// ----------------------------------------------------------------------------
// scaled_moving_sum_filter_tb: self-checking bench for the boxcar filter
// A directed table covers the extremes, the zero, oversized and masked
// window lengths and the start-up partial sums. Random phases follow with
// new register settings, then one phase with the longest window that ends
// without idling. A built-in model predicts every scaled window sum, and
// each result item is compared in order while both channels may idle and
// stall at random.
// ----------------------------------------------------------------------------
module scaled_moving_sum_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandPhases  = 8;
  localparam int PhaseItems  = 40;
  localparam int LongItems   = 160;
  localparam int CalmItems   = 100;
  localparam int LongHold    = 48;
  localparam int DrainCycles = 8;
  localparam int NumDirected = 30;

  typedef logic [smsf_pkg::CfgDataWidth-1:0] cfg_word_t;

  typedef struct {
    bit                  is_write;
    smsf_pkg::reg_idx_e  idx;
    cfg_word_t           value;
    bit                  typed;
    smsf_pkg::result_t   want;
  } stim_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we;
  logic [smsf_pkg::CfgIdxWidth-1:0] cfg_idx;
  cfg_word_t                        cfg_data;

  smsf_sample_if sample_ch ();
  smsf_result_if result_ch ();

  scaled_moving_sum_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .din_i      (sample_ch),
    .dout_o     (result_ch)
  );

  always #10 clk_i = ~clk_i;

  // Filter model state.
  smsf_pkg::sample_t hist_mem [smsf_pkg::MaxLength];
  int unsigned       wr_ptr;
  longint            run_sum;
  int unsigned       win_len;
  longint            gain;

  smsf_pkg::result_t pending_sums [$];
  smsf_pkg::result_t want_sum;
  int                mismatch_count = 0;
  bit                idle_on = 1'b1;
  bit                hold_off_req = 1'b0;

  stim_row_t directed_rows [NumDirected] = '{
    '{1'b0, smsf_pkg::RegWindowLength, 16'h7FFF, 1'b1, 42'sd32767},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h8000, 1'b1, -42'sd32768},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h0001, 1'b1, 42'sd1},
    '{1'b0, smsf_pkg::RegWindowLength, 16'hFFFF, 1'b1, -42'sd1},
    '{1'b1, smsf_pkg::RegScaleFactor,  16'h8000, 1'b0, '0},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h8000, 1'b1, 42'sd1073741824},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h7FFF, 1'b1, -42'sd1073709056},
    '{1'b1, smsf_pkg::RegScaleFactor,  16'h7FFF, 1'b0, '0},
    '{1'b1, smsf_pkg::RegWindowLength, 16'h0000, 1'b0, '0},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h8000, 1'b1, -42'sd1073709056},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h0003, 1'b1, 42'sd98301},
    '{1'b1, smsf_pkg::RegScaleFactor,  16'h0001, 1'b0, '0},
    '{1'b1, smsf_pkg::RegWindowLength, 16'h07FF, 1'b0, '0},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h7FFF, 1'b1, 42'sd32767},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h7FFF, 1'b1, 42'sd65534},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h8000, 1'b1, 42'sd32766},
    '{1'b1, smsf_pkg::RegWindowLength, 16'h0800, 1'b0, '0},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h0005, 1'b1, 42'sd5},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h0007, 1'b1, 42'sd7},
    '{1'b1, smsf_pkg::RegWindowLength, 16'h0003, 1'b0, '0},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h000A, 1'b1, 42'sd10},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h0014, 1'b1, 42'sd30},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h001E, 1'b1, 42'sd60},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h0028, 1'b1, 42'sd90},
    '{1'b1, smsf_pkg::RegScaleFactor,  16'h0000, 1'b0, '0},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h1234, 1'b1, 42'sd0},
    '{1'b1, smsf_pkg::RegScaleFactor,  16'hFFFF, 1'b0, '0},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h0064, 1'b0, '0},
    '{1'b1, smsf_pkg::RegWindowLength, 16'h0400, 1'b0, '0},
    '{1'b0, smsf_pkg::RegWindowLength, 16'h5A5A, 1'b0, '0}
  };

  function automatic void clear_history();
    foreach (hist_mem[i]) hist_mem[i] = '0;
    wr_ptr  = 0;
    run_sum = 0;
  endfunction

  function automatic void apply_reg_write(smsf_pkg::reg_idx_e idx, cfg_word_t data);
    case (idx)
      smsf_pkg::RegWindowLength: begin
        win_len = int'(data[smsf_pkg::LenWidth-1:0]);
        clear_history();
      end
      smsf_pkg::RegScaleFactor: begin
        gain = longint'(smsf_pkg::scale_t'(data));
      end
      default: begin
      end
    endcase
  endfunction

  // Adds the new sample, drops the one leaving the window and scales the sum.
  function automatic smsf_pkg::result_t next_scaled_sum(smsf_pkg::sample_t s);
    int unsigned span;
    int unsigned old_slot;
    longint      product;
    span     = (win_len == 0) ? 1 :
               ((win_len > smsf_pkg::MaxLength) ? smsf_pkg::MaxLength : win_len);
    old_slot = (wr_ptr + smsf_pkg::MaxLength - span) % smsf_pkg::MaxLength;
    run_sum  = run_sum + longint'(s) - longint'(hist_mem[old_slot]);
    hist_mem[wr_ptr] = s;
    wr_ptr   = (wr_ptr + 1) % smsf_pkg::MaxLength;
    product  = run_sum * gain;
    return product[smsf_pkg::OutWidth-1:0];
  endfunction

  function automatic smsf_pkg::sample_t pick_sample();
    case ($urandom_range(0, 5))
      0: return smsf_pkg::sample_t'(16'h7FFF);
      1: return smsf_pkg::sample_t'(16'h8000);
      2: return smsf_pkg::sample_t'($urandom_range(0, 31)) - smsf_pkg::sample_t'(16);
      default: return smsf_pkg::sample_t'($urandom());
    endcase
  endfunction

  task automatic push_sample(smsf_pkg::sample_t s, bit typed, smsf_pkg::result_t want);
    int                gap;
    smsf_pkg::result_t predicted;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk_i);
      sample_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    do @(posedge clk_i); while (!sample_ch.ready);
    predicted = next_scaled_sum(s);
    pending_sums.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    sample_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(smsf_pkg::reg_idx_e idx, cfg_word_t data);
    wait_idle();
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    apply_reg_write(idx, data);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  initial begin : stimulus
    cfg_word_t len_word;
    cfg_word_t scale_word;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    clear_history();
    win_len = 1;
    gain    = 1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        push_sample(smsf_pkg::sample_t'(directed_rows[i].value), directed_rows[i].typed,
                    directed_rows[i].want);
      end
    end

    for (int p = 0; p < RandPhases; p++) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0: len_word = cfg_word_t'(1);
          1: len_word = cfg_word_t'($urandom_range(2, 8));
          2: len_word = cfg_word_t'($urandom_range(9, 64));
          3: len_word = cfg_word_t'($urandom_range(65, smsf_pkg::MaxLength - 1));
          4: len_word = cfg_word_t'(smsf_pkg::MaxLength);
          default: len_word = cfg_word_t'($urandom());
        endcase
        write_reg(smsf_pkg::RegWindowLength, len_word);
      end
      case ($urandom_range(0, 3))
        0: scale_word = 16'h8000;
        1: scale_word = 16'h7FFF;
        2: scale_word = cfg_word_t'($urandom_range(0, 15) - 8);
        default: scale_word = cfg_word_t'($urandom());
      endcase
      write_reg(smsf_pkg::RegScaleFactor, scale_word);
      idle_on = ($urandom_range(0, 2) != 0);
      if (p == 1) begin
        idle_on      = 1'b0;
        hold_off_req = 1'b1;
      end
      for (int k = 0; k < PhaseItems; k++) begin
        push_sample(pick_sample(), 1'b0, '0);
      end
    end

    // The longest window takes most negative samples first, then random ones.
    write_reg(smsf_pkg::RegWindowLength, cfg_word_t'(smsf_pkg::MaxLength));
    write_reg(smsf_pkg::RegScaleFactor, 16'h8000);
    idle_on = 1'b1;
    for (int k = 0; k < LongItems; k++) begin
      if (k == LongItems - CalmItems) idle_on = 1'b0;
      push_sample((k < LongItems / 2) ? smsf_pkg::sample_t'(16'h8000) : pick_sample(),
                  1'b0, '0);
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int hold;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 10);
        result_ch.ready <= 1'b0;
        repeat (hold - 1) @(negedge clk_i);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: average_out mismatch: expected none, actual %0d", $time,
                 result_ch.average_out);
        mismatch_count++;
      end else begin
        want_sum = pending_sums.pop_front();
        if (result_ch.average_out !== want_sum) begin
          $display("%0t: average_out mismatch: expected %0d, actual %0d", $time,
                   want_sum, result_ch.average_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
